### design/clamp_gamma_pixel_to_rgb8_macros.svh
// assertion macros for the gamma correction block
// used by clamp_gamma_pixel_to_rgb8; expects a clock named clk and a reset named rst
`ifndef CLAMP_GAMMA_PIXEL_TO_RGB8_MACROS_SVH
`define CLAMP_GAMMA_PIXEL_TO_RGB8_MACROS_SVH

// property checked outside reset
`define CGP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cgp assertion failed");

// property checked also across reset
`define CGP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cgp assertion failed");

`endif

### design/cgp_pkg.sv
// types, constants and constant tables of the gamma correction pipeline
// no dependencies
package cgp_pkg;

  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned IN_W       = 20;
  localparam int unsigned GAMMA_W    = 16;
  localparam int unsigned LOG_STEPS  = 16;
  localparam int unsigned EXP_STEPS  = 16;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd4096;
  localparam logic [IN_W-1:0] FULL_SCALE = IN_W'(255 << FRAC_BITS);
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // channel kind codes
  localparam logic [1:0] KIND_CALC = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] m;     // log mantissa, Q1.30
    logic [20:0] lg;    // log2 / distance, Q.16
    logic [24:0] p;     // exponent product, Q.16
    logic [30:0] r;     // power, Q1.30
    logic [7:0]  o;     // final code
  } chan_t;

  typedef struct packed {
    logic [GAMMA_W-1:0] gamma;
    chan_t [2:0]        ch;
  } pix_t;

  // floor integer square root, elaboration only
  function automatic logic [63:0] isqrt_c(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] x;
    res = 64'd0;
    bt  = 64'd1 << 62;
    x   = n;
    while (bt > x) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (x >= res + bt) begin
        x   = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // c_k, close to 2^(30 - 2^-k)
  function automatic logic [30:0] root_c(input int k);
    logic [63:0] r;
    r = isqrt_c(64'd1 << 59);
    for (int j = 2; j <= k; j++) r = isqrt_c(r << 30);
    return r[30:0];
  endfunction

  // log2 in Q.16, same rounding as the pipeline
  function automatic logic [20:0] log2_c(input logic [63:0] v);
    int unsigned e;
    logic [63:0] m;
    logic [20:0] res;
    e = 0;
    while (e < 29 && (v >> (e + 1)) != 64'd0) e++;
    m   = v << (30 - e);
    res = 21'(e) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  localparam logic [20:0] LOG_FS = log2_c(64'(FULL_SCALE));

endpackage

### design/cgp_if.sv
// pixel stream interfaces, valid/ready with payload
// depends on cgp_pkg
interface cgp_in_if import cgp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] red_in;
  logic signed [IN_W-1:0] green_in;
  logic signed [IN_W-1:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface cgp_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

### design/clamp_gamma_pixel_to_rgb8.sv
// gamma correction of one linear pixel to 8-bit rgb, log2/exp2 pipeline
// depends on cgp_pkg, cgp_if and the macros header
//
//  channel   dir  payload                         handshake
//  pix_in    in   red_in, green_in, blue_in (s20)  valid/ready
//  pix_out   out  red_out, green_out, blue_out (8) valid/ready
//  cfg       in   cfg_wdata (gamma, Q4.12)         cfg_we, no wait
//
// 37 register stages: entry, 16 log squarings, distance, product, 16 root
// multiplies, shift, scale. items are accepted one per cycle while the output
// does not stall.
// a stall at the output freezes the whole pipeline; nothing is lost.
// rst is synchronous and clears the valid bits and sets gamma to 1.0.
`include "clamp_gamma_pixel_to_rgb8_macros.svh"

module clamp_gamma_pixel_to_rgb8 import cgp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [GAMMA_W-1:0] cfg_wdata,
  cgp_in_if.sink             pix_in,
  cgp_out_if.source          pix_out
);

  localparam int NSTAGE  = 1 + LOG_STEPS + 2 + EXP_STEPS + 2;
  localparam int ST_T    = LOG_STEPS + 1;
  localparam int ST_P    = LOG_STEPS + 2;
  localparam int ST_SH   = ST_P + EXP_STEPS + 1;
  localparam int ST_LAST = NSTAGE - 1;

  logic [GAMMA_W-1:0] gamma;
  logic [NSTAGE-1:0]  vld;
  pix_t               pipe [NSTAGE];
  logic               en;

  // gamma register
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (cfg_we) begin
      gamma <= cfg_wdata;
    end
  end

  // global advance
  assign en           = !vld[ST_LAST] || pix_out.ready;
  assign pix_in.ready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], pix_in.valid};
    end
  end

  // entry: clamp, classify, leading one
  logic signed [IN_W-1:0] raw [3];
  assign raw[0] = pix_in.red_in;
  assign raw[1] = pix_in.green_in;
  assign raw[2] = pix_in.blue_in;

  pix_t entry;
  always_comb begin
    logic [IN_W-1:0] v;
    logic [4:0]      e;
    entry       = '0;
    entry.gamma = gamma;
    for (int c = 0; c < 3; c++) begin
      v = raw[c][IN_W-1] ? '0 : IN_W'(raw[c]);
      e = '0;
      for (int b = 0; b < IN_W; b++) begin
        if (v[b]) e = 5'(b);
      end
      entry.ch[c].m  = 31'({11'd0, v} << (5'd30 - e));
      entry.ch[c].lg = {e, 16'd0};
      if (gamma == '0 || v >= FULL_SCALE) begin
        entry.ch[c].kind = KIND_FULL;
      end else if (v == '0) begin
        entry.ch[c].kind = KIND_ZERO;
      end else begin
        entry.ch[c].kind = KIND_CALC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) pipe[0] <= entry;
  end

  genvar s;
  generate
    for (s = 1; s < NSTAGE; s++) begin : g_st
      pix_t nxt;
      if (s <= LOG_STEPS) begin : g_log
        // one fraction bit of the log per squaring
        always_comb begin
          logic [61:0] sq;
          nxt = pipe[s-1];
          for (int c = 0; c < 3; c++) begin
            sq = 62'(pipe[s-1].ch[c].m) * 62'(pipe[s-1].ch[c].m);
            if (sq[61]) begin
              nxt.ch[c].m = sq[61:31];
              nxt.ch[c].lg[LOG_STEPS-s] = 1'b1;
            end else begin
              nxt.ch[c].m = sq[60:30];
            end
          end
        end
      end else if (s == ST_T) begin : g_dist
        // distance below full scale, floored at zero
        always_comb begin
          nxt = pipe[s-1];
          for (int c = 0; c < 3; c++) begin
            nxt.ch[c].lg = (LOG_FS > pipe[s-1].ch[c].lg) ?
                           LOG_FS - pipe[s-1].ch[c].lg : '0;
          end
        end
      end else if (s == ST_P) begin : g_prod
        // exponent product, underflow check
        always_comb begin
          logic [36:0] pr;
          nxt = pipe[s-1];
          for (int c = 0; c < 3; c++) begin
            pr = 37'(pipe[s-1].ch[c].lg) * 37'(pipe[s-1].gamma);
            nxt.ch[c].p = pr[36:12];
            nxt.ch[c].r = ONE_Q30;
            if (pipe[s-1].ch[c].kind == KIND_CALC && pr[36:28] > 9'd30) begin
              nxt.ch[c].kind = KIND_ZERO;
            end
          end
        end
      end else if (s < ST_SH) begin : g_exp
        localparam int K = s - ST_P;
        localparam logic [30:0] ROOT = root_c(K);
        // multiply by the root for this fraction bit
        always_comb begin
          logic [61:0] pr;
          nxt = pipe[s-1];
          for (int c = 0; c < 3; c++) begin
            pr = 62'(pipe[s-1].ch[c].r) * 62'(ROOT);
            if (pipe[s-1].ch[c].p[16-K]) nxt.ch[c].r = pr[60:30];
          end
        end
      end else if (s == ST_SH) begin : g_shift
        // integer part of the exponent
        always_comb begin
          nxt = pipe[s-1];
          for (int c = 0; c < 3; c++) begin
            nxt.ch[c].r = pipe[s-1].ch[c].r >> pipe[s-1].ch[c].p[20:16];
          end
        end
      end else begin : g_scale
        // scale by 255, saturate, apply special cases
        always_comb begin
          logic [38:0] sc;
          nxt = pipe[s-1];
          for (int c = 0; c < 3; c++) begin
            sc = 39'(pipe[s-1].ch[c].r) * 39'd255;
            unique case (pipe[s-1].ch[c].kind)
              KIND_FULL: nxt.ch[c].o = 8'd255;
              KIND_ZERO: nxt.ch[c].o = 8'd0;
              default:   nxt.ch[c].o = sc[38] ? 8'd255 : sc[37:30];
            endcase
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) pipe[s] <= nxt;
      end
    end
  endgenerate

  // outputs
  assign pix_out.valid     = vld[ST_LAST];
  assign pix_out.red_out   = pipe[ST_LAST].ch[0].o;
  assign pix_out.green_out = pipe[ST_LAST].ch[1].o;
  assign pix_out.blue_out  = pipe[ST_LAST].ch[2].o;

  // checks
  `CGP_ASSERT(a_stall_only_on_output, !pix_in.ready |-> pix_out.valid && !pix_out.ready)
  `CGP_ASSERT_ALWAYS(a_gamma_reset, $past(rst) && !$past(cfg_we) |-> gamma == GAMMA_RESET)
  `CGP_ASSERT(a_calc_ip_range, pipe[ST_P].ch[0].kind == KIND_CALC |-> pipe[ST_P].ch[0].p[24:16] <= 9'd30)
  `CGP_ASSERT(a_power_bound, vld[ST_SH] |-> pipe[ST_SH].ch[1].r <= ONE_Q30)

endmodule

### bench/testbench.sv
// testbench for clamp_gamma_pixel_to_rgb8: directed and random pixels through the gamma pipeline
// depends on cgp_pkg, cgp_if and the block; checks every result against its own predictor
`timescale 1ns / 1ps

module testbench;
  import cgp_pkg::*;

  localparam int LATENCY   = 37;
  localparam int N_RANDOM  = 1600;
  localparam longint LIMIT = 400000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb8_t;

  // scoreboard: predicts each accepted pixel and matches outputs in order
  class gamma_scoreboard;
    logic [63:0] roots[17];
    logic [15:0] gamma;
    rgb8_t pending[$];
    int errors;

    function new();
      logic [63:0] r;
      r = sqrt_floor(64'd1 << 59);
      roots[0] = 64'd1 << 30;
      roots[1] = r;
      for (int k = 2; k <= 16; k++) begin
        r = sqrt_floor(r << 30);
        roots[k] = r;
      end
      gamma = 16'd4096;
      errors = 0;
    endfunction

    function logic [63:0] sqrt_floor(logic [63:0] n);
      logic [63:0] res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
        if (n >= res + bt) begin
          n = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    function logic [63:0] log2_fixed(logic [63:0] v);
      int e;
      logic [63:0] m, res;
      e = 0;
      while (e < 29 && (v >> (e + 1)) != 0) e++;
      m = v << (30 - e);
      res = 64'(e) << 16;
      for (int i = 15; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          res[i] = 1'b1;
        end
      end
      return res;
    endfunction

    function logic [7:0] correct(logic [19:0] raw);
      logic [63:0] v, fs, lf, lv, t, p, r;
      logic [15:0] f;
      longint ip;
      fs = 64'd255 << 8;
      v = raw[19] ? 64'd0 : 64'(raw);
      if (gamma == 0) return 8'd255;
      if (v >= fs) return 8'd255;
      if (v == 0) return 8'd0;
      lf = log2_fixed(fs);
      lv = log2_fixed(v);
      t = (lf > lv) ? lf - lv : 0;
      p = (t * gamma) >> 12;
      ip = p >> 16;
      f = p[15:0];
      if (ip > 30) return 8'd0;
      r = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
        if (f[16 - k]) r = (r * roots[k]) >> 30;
      r = r >> ip;
      r = (64'd255 * r) >> 30;
      return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function void note_pixel(logic [19:0] rd, logic [19:0] gr, logic [19:0] bl);
      rgb8_t e;
      e.red = correct(rd);
      e.green = correct(gr);
      e.blue = correct(bl);
      pending.push_back(e);
    endfunction

    function void check_pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
      rgb8_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel %0d %0d %0d", $time, rd, gr, bl);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rd !== e.red) begin
        $display("%0t: red expected %0d actual %0d", $time, e.red, rd);
        errors++;
      end
      if (gr !== e.green) begin
        $display("%0t: green expected %0d actual %0d", $time, e.green, gr);
        errors++;
      end
      if (bl !== e.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, e.blue, bl);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [GAMMA_W-1:0] cfg_wdata;
  longint cycles;
  bit calm;          // no idling on either side
  int hold_off;      // receiver holds off this many cycles
  gamma_scoreboard board;

  cgp_in_if pin();
  cgp_out_if pout();

  clamp_gamma_pixel_to_rgb8 uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pix_in(pin.sink), .pix_out(pout.source)
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("[clamp_gamma_pixel_to_rgb8] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    pout.ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && pout.valid && pout.ready)
        board.check_pixel(pout.red_out, pout.green_out, pout.blue_out);
      if (hold_off > 0) begin
        hold_off--;
        pout.ready <= 0;
      end else begin
        pout.ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  // random channel value, weighted toward the interesting range
  function automatic logic [19:0] pick_channel();
    case ($urandom_range(9))
      0: return 20'($urandom);
      1: return 20'(-$urandom_range(2000));
      2: return 20'($urandom_range(15));
      3: return 20'(65280 + $urandom_range(20) - 10);
      default: return 20'($urandom_range(65279));
    endcase
  endfunction

  // offer one pixel until it is accepted
  task automatic send_pixel(logic [19:0] rd, logic [19:0] gr, logic [19:0] bl);
    while (!calm && $urandom_range(99) < 8) begin
      pin.valid <= 0;
      @(posedge clk);
    end
    pin.valid <= 1;
    pin.red_in <= rd;
    pin.green_in <= gr;
    pin.blue_in <= bl;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    board.note_pixel(rd, gr, bl);
  endtask

  // wait until the pipeline is empty
  task automatic drain();
    pin.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_gamma(logic [15:0] g);
    cfg_we <= 1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 0;
    board.gamma = g;
  endtask

  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++) send_pixel(pick_channel(), pick_channel(), pick_channel());
  endtask

  logic [15:0] settings[8] = '{16'd4096, 16'd0, 16'd65535, 16'd1, 16'd9011,
                                16'd2048, 16'd1862, 16'd30000};

  initial begin
    board = new();
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    calm = 0;
    hold_off = 0;
    pin.valid = 0;
    pin.red_in = 0;
    pin.green_in = 0;
    pin.blue_in = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes and special cases at reset gamma
    send_pixel(20'h00000, 20'h7FFFF, 20'h80000);
    send_pixel(20'd65280, 20'd65279, 20'd1);
    send_pixel(20'hFFFFF, 20'd256, 20'd32768);
    send_pixel(20'h55555, 20'hAAAAA, 20'd128);
    drain();
    write_gamma(16'd0);
    send_pixel(20'd0, 20'h80000, 20'd1000);
    send_pixel(20'd65280, 20'd1, 20'h7FFFF);
    drain();
    write_gamma(16'hFFFF);
    send_pixel(20'd1, 20'd100, 20'd65000);
    send_pixel(20'd0, 20'd65279, 20'd4096);
    drain();

    // random phases over several gamma settings
    foreach (settings[s]) begin
      write_gamma(s < 5 ? settings[s] : 16'($urandom));
      if (s == 2) begin
        // long receiver hold-off while the sender keeps offering
        hold_off = 200;
        random_pixels(100);
      end else if (s == 3) begin
        calm = 1;
        random_pixels(150);
        calm = 0;
      end else begin
        random_pixels(N_RANDOM / 8);
      end
      drain();
    end
    write_gamma(settings[0]);
    random_pixels(50);
    drain();

    if (board.errors == 0) begin
      $display("[clamp_gamma_pixel_to_rgb8] OK");
    end else begin
      $display("[clamp_gamma_pixel_to_rgb8] ERROR");
    end
    $finish;
  end
endmodule
